>>> sv/mbe_pkg.sv
// Shared types and constants for the multipart body extractor.
// No dependencies; used by mbe_ctrl and the top level.
`default_nettype none

package mbe_pkg;

  localparam int MAX_BND         = 56;
  localparam int MAX_HEADER_BYTES = 1024;
  localparam int WIN_DEPTH       = MAX_BND + 4;
  localparam int FILL_W          = $clog2(WIN_DEPTH + 1);
  localparam int WIN_IDX_W       = $clog2(WIN_DEPTH);
  localparam int HDR_CNT_W       = $clog2(MAX_HEADER_BYTES);
  localparam int BND_LEN_W       = 6;
  localparam int NUM_BND_REGS    = 7;
  localparam int CFG_IDX_W       = $clog2(NUM_BND_REGS + 1);
  localparam int CFG_DATA_W      = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEN = CFG_IDX_W'(NUM_BND_REGS);

  localparam logic [7:0] CHR_CR   = 8'h0D;
  localparam logic [7:0] CHR_LF   = 8'h0A;
  localparam logic [7:0] CHR_DASH = 8'h2D;
  localparam logic [31:0] HDR_END_SEQ = 32'h0D0A0D0A;

  // leading bytes of the closing delimiter: CR LF - -
  localparam logic [7:0] DELIM_HEAD [4] = '{8'h0D, 8'h0A, 8'h2D, 8'h2D};

  typedef enum logic [2:0] {
    M_PREAMBLE  = 3'd0,
    M_EXPECT_CR = 3'd1,
    M_EXPECT_LF = 3'd2,
    M_HEADERS   = 3'd3,
    M_BODY      = 3'd4,
    M_DONE      = 3'd5
  } parse_mode_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EVAL   = 2'd1,
    S_FLUSH  = 2'd2,
    S_STATUS = 2'd3
  } ctrl_state_e;

  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_STATUS = 1'b1
  } result_kind_e;

  typedef enum logic [1:0] {
    ST_CLOSED     = 2'd0,
    ST_NO_DELIM   = 2'd1,
    ST_NO_BODY    = 2'd2,
    ST_HDR_LIMIT  = 2'd3
  } end_status_e;

  // Control from the sequencer to the cell row.
  typedef struct packed {
    logic                 wr;
    logic                 shift;
    logic [WIN_IDX_W-1:0] wpos;
    logic [7:0]           din;
    logic                 lead4;
    logic [FILL_W-1:0]    cmp_len;
  } chain_ctl_t;

endpackage

`default_nettype wire

>>> sv/mbe_cell.sv
// One byte cell of the delay/match window.
// Depends on mbe_pkg only through the top level's wiring.
`default_nettype none

module mbe_cell (
  input  wire logic       clk_i,
  input  wire logic       shift_i,
  input  wire logic       wr_i,
  input  wire logic [7:0] din_i,
  input  wire logic [7:0] nbr_i,
  input  wire logic [7:0] pat2_i,
  input  wire logic [7:0] pat4_i,
  input  wire logic       lead4_i,
  input  wire logic       active_i,
  input  wire logic       match_i,
  output logic      [7:0] byte_o,
  output logic            match_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;
  logic       eq;

  always_comb begin
    if (wr_i) begin
      byte_d = din_i;
    end else if (shift_i) begin
      byte_d = nbr_i;
    end else begin
      byte_d = byte_q;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign eq      = lead4_i ? (byte_q == pat4_i) : (byte_q == pat2_i);
  // cells past the pattern length do not take part
  assign match_o = match_i & (eq | ~active_i);
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

>>> sv/mbe_ctrl.sv
// Sequencer: parse modes, header counting, flush and the output register.
// Depends on mbe_pkg; drives the cell row through mbe_pkg::chain_ctl_t.
`default_nettype none

module mbe_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          start_of_request_i,
  input  wire logic                          end_of_request_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               result_kind_o,
  output logic [7:0]                         body_byte_o,
  output logic [1:0]                         end_status_o,
  output logic                               last_result_o,
  input  wire logic [mbe_pkg::BND_LEN_W-1:0] bnd_len_i,
  output mbe_pkg::chain_ctl_t                chain_o,
  input  wire logic                          chain_match_i,
  input  wire logic [7:0]                    head_byte_i
);

  typedef struct packed {
    logic [mbe_pkg::HDR_CNT_W-1:0] cnt;
    logic [31:0]                   win;
    logic                          hdr_end;
    logic                          limit;
  } hdr_res_t;

  function automatic hdr_res_t hdr_step(input logic [mbe_pkg::HDR_CNT_W-1:0] cnt,
                                        input logic [31:0] win,
                                        input logic [7:0] x);
    hdr_res_t                    r;
    logic [mbe_pkg::HDR_CNT_W:0] c1;
    c1        = {1'b0, cnt} + (mbe_pkg::HDR_CNT_W + 1)'(1);
    r.win     = {win[23:0], x};
    r.hdr_end = (c1 >= (mbe_pkg::HDR_CNT_W + 1)'(4)) && (r.win == mbe_pkg::HDR_END_SEQ);
    r.limit   = !r.hdr_end &&
                (c1 >= (mbe_pkg::HDR_CNT_W + 1)'(mbe_pkg::MAX_HEADER_BYTES - 1));
    r.cnt     = r.hdr_end ? '0 : c1[mbe_pkg::HDR_CNT_W-1:0];
    return r;
  endfunction

  mbe_pkg::ctrl_state_e  state_q, state_d;
  mbe_pkg::parse_mode_e  mode_q, mode_d;
  logic [mbe_pkg::FILL_W-1:0]    fill_q, fill_d;
  logic [mbe_pkg::HDR_CNT_W-1:0] hcnt_q, hcnt_d;
  logic [31:0]                   hwin_q, hwin_d;
  logic                          bs_q, bs_d;
  logic [7:0]                    item_byte_q, item_byte_d;
  logic                          item_eor_q, item_eor_d;

  logic                          out_valid_q, out_valid_d;
  mbe_pkg::result_kind_e         out_kind_q, out_kind_d;
  logic [7:0]                    out_byte_q, out_byte_d;
  mbe_pkg::end_status_e          out_status_q, out_status_d;
  logic                          out_last_q, out_last_d;

  logic [mbe_pkg::BND_LEN_W-1:0] eff_len;
  logic [mbe_pkg::FILL_W-1:0]    plen, clen, cmp_len, cap, fill_eff;
  logic                          out_free, accept, match_all;
  mbe_pkg::parse_mode_e          mode_eff;

  hdr_res_t                      h_a, h_b, h_use;

  mbe_pkg::parse_mode_e          ev_mode;
  logic [mbe_pkg::FILL_W-1:0]    ev_fill;
  logic [mbe_pkg::HDR_CNT_W-1:0] ev_hcnt;
  logic [31:0]                   ev_hwin;
  logic                          ev_bs, ev_shift, ev_emit, ev_last;
  mbe_pkg::result_kind_e         ev_kind;
  logic [7:0]                    ev_byte;
  mbe_pkg::end_status_e          ev_status;

  // boundary length clamp and derived pattern lengths
  always_comb begin
    if (bnd_len_i == '0) begin
      eff_len = mbe_pkg::BND_LEN_W'(1);
    end else if (bnd_len_i > mbe_pkg::BND_LEN_W'(mbe_pkg::MAX_BND)) begin
      eff_len = mbe_pkg::BND_LEN_W'(mbe_pkg::MAX_BND);
    end else begin
      eff_len = bnd_len_i;
    end
  end

  assign plen      = (mbe_pkg::FILL_W)'(eff_len) + (mbe_pkg::FILL_W)'(2);
  assign clen      = (mbe_pkg::FILL_W)'(eff_len) + (mbe_pkg::FILL_W)'(4);
  assign cmp_len   = (mode_q == mbe_pkg::M_BODY) ? clen : plen;
  assign match_all = chain_match_i && (fill_q == cmp_len);

  assign in_stall_o = (state_q != mbe_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign mode_eff = start_of_request_i ? mbe_pkg::M_PREAMBLE : mode_q;
  assign fill_eff = start_of_request_i ? '0 : fill_q;
  assign cap      = (mode_eff == mbe_pkg::M_PREAMBLE) ? plen
                                                      : (mbe_pkg::FILL_W)'(mbe_pkg::WIN_DEPTH);

  // header bytes; a lone CR after the boundary is fed ahead of the byte
  assign h_a   = hdr_step(hcnt_q, hwin_q,
                          (mode_q == mbe_pkg::M_EXPECT_LF) ? mbe_pkg::CHR_CR : item_byte_q);
  assign h_b   = hdr_step(h_a.cnt, h_a.win, item_byte_q);
  assign h_use = (mode_q == mbe_pkg::M_EXPECT_LF && !h_a.limit) ? h_b : h_a;

  // one parse step on the window as it stands after the push
  always_comb begin
    ev_mode   = mode_q;
    ev_fill   = fill_q;
    ev_hcnt   = hcnt_q;
    ev_hwin   = hwin_q;
    ev_bs     = bs_q;
    ev_shift  = 1'b0;
    ev_emit   = 1'b0;
    ev_kind   = mbe_pkg::KIND_STATUS;
    ev_byte   = '0;
    ev_status = mbe_pkg::ST_CLOSED;
    ev_last   = 1'b1;
    unique case (mode_q)
      mbe_pkg::M_PREAMBLE: begin
        if (match_all) begin
          ev_mode = mbe_pkg::M_EXPECT_CR;
          ev_fill = '0;
        end
      end
      mbe_pkg::M_EXPECT_CR, mbe_pkg::M_EXPECT_LF, mbe_pkg::M_HEADERS: begin
        if (mode_q == mbe_pkg::M_EXPECT_CR && item_byte_q == mbe_pkg::CHR_CR) begin
          ev_mode = mbe_pkg::M_EXPECT_LF;
        end else if (mode_q == mbe_pkg::M_EXPECT_LF && item_byte_q == mbe_pkg::CHR_LF) begin
          ev_mode = mbe_pkg::M_HEADERS;
        end else begin
          ev_hcnt = h_use.cnt;
          ev_hwin = h_use.win;
          if (h_use.hdr_end) begin
            ev_mode = mbe_pkg::M_BODY;
            ev_fill = '0;
          end else if (h_use.limit) begin
            ev_mode   = mbe_pkg::M_DONE;
            ev_fill   = '0;
            ev_emit   = 1'b1;
            ev_status = mbe_pkg::ST_HDR_LIMIT;
          end else begin
            ev_mode = mbe_pkg::M_HEADERS;
          end
        end
      end
      mbe_pkg::M_BODY: begin
        if (match_all) begin
          ev_mode   = mbe_pkg::M_DONE;
          ev_fill   = '0;
          ev_emit   = 1'b1;
          ev_status = bs_q ? mbe_pkg::ST_CLOSED : mbe_pkg::ST_NO_BODY;
        end else if (fill_q >= clen) begin
          ev_emit  = 1'b1;
          ev_kind  = mbe_pkg::KIND_BYTE;
          ev_byte  = head_byte_i;
          ev_last  = !item_eor_q;
          ev_bs    = 1'b1;
          ev_shift = 1'b1;
          ev_fill  = fill_q - (mbe_pkg::FILL_W)'(1);
        end
      end
      mbe_pkg::M_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbe_pkg::S_IDLE: begin
        if (accept) state_d = mbe_pkg::S_EVAL;
      end
      mbe_pkg::S_EVAL: begin
        if (out_free) begin
          priority if (!item_eor_q) begin
            state_d = mbe_pkg::S_IDLE;
          end else if (ev_mode == mbe_pkg::M_BODY && ev_fill != '0) begin
            state_d = mbe_pkg::S_FLUSH;
          end else if (ev_mode != mbe_pkg::M_DONE) begin
            state_d = mbe_pkg::S_STATUS;
          end else begin
            state_d = mbe_pkg::S_IDLE;
          end
        end
      end
      mbe_pkg::S_FLUSH: begin
        if (out_free && fill_q == (mbe_pkg::FILL_W)'(1)) state_d = mbe_pkg::S_STATUS;
      end
      mbe_pkg::S_STATUS: begin
        if (out_free) state_d = mbe_pkg::S_IDLE;
      end
      default: state_d = mbe_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_d       = mode_q;
    fill_d       = fill_q;
    hcnt_d       = hcnt_q;
    hwin_d       = hwin_q;
    bs_d         = bs_q;
    item_byte_d  = item_byte_q;
    item_eor_d   = item_eor_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_kind_d   = out_kind_q;
    out_byte_d   = out_byte_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    chain_o.wr      = 1'b0;
    chain_o.shift   = 1'b0;
    chain_o.wpos    = '0;
    chain_o.din     = data_byte_i;
    chain_o.lead4   = (mode_q == mbe_pkg::M_BODY);
    chain_o.cmp_len = cmp_len;
    unique case (state_q)
      mbe_pkg::S_IDLE: begin
        if (accept) begin
          item_byte_d = data_byte_i;
          item_eor_d  = end_of_request_i;
          mode_d      = mode_eff;
          fill_d      = fill_eff;
          if (start_of_request_i) begin
            hcnt_d = '0;
            bs_d   = 1'b0;
          end
          if (mode_eff == mbe_pkg::M_PREAMBLE || mode_eff == mbe_pkg::M_BODY) begin
            chain_o.wr = 1'b1;
            if (fill_eff >= cap) begin
              // full: drop the oldest byte, new one lands at the top
              chain_o.shift = 1'b1;
              chain_o.wpos  = (mbe_pkg::WIN_IDX_W)'(cap - (mbe_pkg::FILL_W)'(1));
              fill_d        = cap;
            end else begin
              chain_o.wpos = (mbe_pkg::WIN_IDX_W)'(fill_eff);
              fill_d       = fill_eff + (mbe_pkg::FILL_W)'(1);
            end
          end
        end
      end
      mbe_pkg::S_EVAL: begin
        if (out_free) begin
          mode_d        = ev_mode;
          fill_d        = ev_fill;
          hcnt_d        = ev_hcnt;
          hwin_d        = ev_hwin;
          bs_d          = ev_bs;
          chain_o.shift = ev_shift;
          if (ev_emit) begin
            out_valid_d  = 1'b1;
            out_kind_d   = ev_kind;
            out_byte_d   = ev_byte;
            out_status_d = ev_status;
            out_last_d   = ev_last;
          end
          if (item_eor_q && ev_mode == mbe_pkg::M_DONE) begin
            mode_d = mbe_pkg::M_PREAMBLE;
            fill_d = '0;
            hcnt_d = '0;
            bs_d   = 1'b0;
          end
        end
      end
      mbe_pkg::S_FLUSH: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_kind_d    = mbe_pkg::KIND_BYTE;
          out_byte_d    = head_byte_i;
          out_status_d  = mbe_pkg::ST_CLOSED;
          out_last_d    = 1'b0;
          chain_o.shift = 1'b1;
          fill_d        = fill_q - (mbe_pkg::FILL_W)'(1);
          bs_d          = 1'b1;
        end
      end
      mbe_pkg::S_STATUS: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = mbe_pkg::KIND_STATUS;
          out_byte_d   = '0;
          out_status_d = (mode_q == mbe_pkg::M_BODY && bs_q) ? mbe_pkg::ST_NO_DELIM
                                                             : mbe_pkg::ST_NO_BODY;
          out_last_d   = 1'b1;
          mode_d       = mbe_pkg::M_PREAMBLE;
          fill_d       = '0;
          hcnt_d       = '0;
          bs_d         = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbe_pkg::S_IDLE;
      mode_q      <= mbe_pkg::M_PREAMBLE;
      fill_q      <= '0;
      hcnt_q      <= '0;
      bs_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      fill_q      <= fill_d;
      hcnt_q      <= hcnt_d;
      bs_q        <= bs_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hwin_q       <= hwin_d;
    item_byte_q  <= item_byte_d;
    item_eor_q   <= item_eor_d;
    out_kind_q   <= out_kind_d;
    out_byte_q   <= out_byte_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign body_byte_o   = out_byte_q;
  assign end_status_o  = out_status_q;
  assign last_result_o = out_last_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (mbe_pkg::FILL_W)'(mbe_pkg::WIN_DEPTH))
    else $error("window fill beyond depth");

  a_flush_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mbe_pkg::S_FLUSH) |-> (fill_q != '0))
    else $error("flush with empty window");

  a_status_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mbe_pkg::S_STATUS && out_free) |=>
      (state_q == mbe_pkg::S_IDLE && mode_q == mbe_pkg::M_PREAMBLE && fill_q == '0))
    else $error("end status did not clear parse state");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == mbe_pkg::KIND_STATUS) |-> out_last_q)
    else $error("end status beat not marked last");
`endif

endmodule

`default_nettype wire

>>> sv/multipart_body_extractor.sv
// Multipart body extractor: each accepted byte is taken in and pushed into the
// cell row, then the row is compared and at most one beat emitted; input stalls meanwhile.
// A result beat is registered; it is visible the cycle after evaluation.
// At end of request inside the body, each held byte (up to 59) goes out as its own
// beat, then the status beat follows. Evaluation waits while the output is held.
// Async active-low reset clears control and config; cells above the fill are never read.
`default_nettype none

module multipart_body_extractor (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          start_of_request_i,
  input  wire logic                          end_of_request_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               result_kind_o,
  output logic [7:0]                         body_byte_o,
  output logic [1:0]                         end_status_o,
  output logic                               last_result_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mbe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mbe_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [mbe_pkg::CFG_DATA_W-1:0] bnd_q [mbe_pkg::NUM_BND_REGS];
  logic [mbe_pkg::BND_LEN_W-1:0]  len_q;
  logic [7:0]                     bnd_byte [mbe_pkg::MAX_BND];

  mbe_pkg::chain_ctl_t            chain;
  logic [7:0]                     cell_byte [mbe_pkg::WIN_DEPTH];
  logic [mbe_pkg::WIN_DEPTH:0]    match_chain;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < mbe_pkg::NUM_BND_REGS; r++) begin
        bnd_q[r] <= '0;
      end
      len_q <= mbe_pkg::BND_LEN_W'(1);
    end else if (cfg_we_i) begin
      priority if (cfg_idx_i == mbe_pkg::CFG_IDX_LEN) begin
        len_q <= cfg_wdata_i[mbe_pkg::BND_LEN_W-1:0];
      end else if (cfg_idx_i < mbe_pkg::CFG_IDX_LEN) begin
        bnd_q[cfg_idx_i] <= cfg_wdata_i;
      end else begin
      end
    end
  end

  for (genvar i = 0; i < mbe_pkg::MAX_BND; i++) begin : g_bnd
    assign bnd_byte[i] = bnd_q[i / 8][8 * (i % 8) +: 8];
  end

  assign match_chain[0] = 1'b1;

  for (genvar j = 0; j < mbe_pkg::WIN_DEPTH; j++) begin : g_cell
    logic [7:0] pat2;
    logic [7:0] pat4;
    logic [7:0] nbr;
    logic       active;
    logic       wr;

    if (j < 2) begin : g_p2_dash
      assign pat2 = mbe_pkg::CHR_DASH;
    end else if (j - 2 < mbe_pkg::MAX_BND) begin : g_p2_bnd
      assign pat2 = bnd_byte[j - 2];
    end else begin : g_p2_none
      assign pat2 = '0;
    end

    if (j < 4) begin : g_p4_head
      assign pat4 = mbe_pkg::DELIM_HEAD[j];
    end else begin : g_p4_bnd
      assign pat4 = bnd_byte[j - 4];
    end

    if (j + 1 < mbe_pkg::WIN_DEPTH) begin : g_nbr
      assign nbr = cell_byte[j + 1];
    end else begin : g_nbr_end
      assign nbr = '0;
    end

    assign active = ((mbe_pkg::FILL_W)'(j) < chain.cmp_len);
    assign wr     = chain.wr && (chain.wpos == (mbe_pkg::WIN_IDX_W)'(j));

    mbe_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (chain.shift),
      .wr_i     (wr),
      .din_i    (chain.din),
      .nbr_i    (nbr),
      .pat2_i   (pat2),
      .pat4_i   (pat4),
      .lead4_i  (chain.lead4),
      .active_i (active),
      .match_i  (match_chain[j]),
      .byte_o   (cell_byte[j]),
      .match_o  (match_chain[j + 1])
    );
  end

  mbe_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .start_of_request_i (start_of_request_i),
    .end_of_request_i   (end_of_request_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_kind_o      (result_kind_o),
    .body_byte_o        (body_byte_o),
    .end_status_o       (end_status_o),
    .last_result_o      (last_result_o),
    .bnd_len_i          (len_q),
    .chain_o            (chain),
    .chain_match_i      (match_chain[mbe_pkg::WIN_DEPTH]),
    .head_byte_i        (cell_byte[0])
  );

endmodule

`default_nettype wire

>>> test/mbe_checker.sv
// Checker for the multipart body extractor: tracks config writes, predicts the
// result beats of every accepted input beat and compares them in order.
// Depends on mbe_pkg for widths, parse modes, result kinds and end status codes.
module mbe_checker
  import mbe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  start_of_request_i,
  input  logic                  end_of_request_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  result_kind_i,
  input  logic [7:0]            body_byte_i,
  input  logic [1:0]            end_status_i,
  input  logic                  last_result_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    byte_beats_o,
  output int                    status_beats_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   data;
    end_status_e  status;
    logic         last;
  } upload_beat_t;

  // boundary registers as written
  logic [CFG_DATA_W-1:0] bnd_reg [NUM_BND_REGS];
  logic [BND_LEN_W-1:0]  bnd_len;

  // parser state
  parse_mode_e mode;
  logic [7:0]  win [WIN_DEPTH];
  int          fill;
  int          hdr_cnt;
  bit          body_seen;

  upload_beat_t step_q [$];
  upload_beat_t expected_q [$];
  upload_beat_t got, want;

  function automatic int eff_len();
    int l;
    l = int'(bnd_len);
    if (l < 1) l = 1;
    if (l > MAX_BND) l = MAX_BND;
    return l;
  endfunction

  // byte k of "--" boundary (lead 2) or CR LF "--" boundary (lead 4)
  function automatic logic [7:0] delim_byte(int lead, int k);
    int i;
    if (k < lead) begin
      i = 4 - lead + k;
      if (i == 0) return CHR_CR;
      if (i == 1) return CHR_LF;
      return CHR_DASH;
    end
    i = k - lead;
    return bnd_reg[i >> 3][8 * (i & 7) +: 8];
  endfunction

  function automatic void clear_parse();
    mode = M_PREAMBLE;
    for (int j = 0; j < WIN_DEPTH; j++) win[j] = 8'h00;
    fill = 0;
    hdr_cnt = 0;
    body_seen = 1'b0;
  endfunction

  function automatic void drop_oldest();
    for (int j = 0; j < WIN_DEPTH - 1; j++) win[j] = win[j + 1];
  endfunction

  function automatic void push_keep(logic [7:0] b, int cap);
    if (fill >= cap) begin
      drop_oldest();
      fill = cap - 1;
    end
    win[fill] = b;
    fill++;
  endfunction

  function automatic bit window_is(int lead, int len);
    if (fill != len) return 1'b0;
    for (int k = 0; k < len; k++)
      if (win[k] != delim_byte(lead, k)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void emit(result_kind_e kind, logic [7:0] d, end_status_e st);
    upload_beat_t r;
    r.kind = kind;
    r.data = d;
    r.status = st;
    r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void header_byte(logic [7:0] b);
    hdr_cnt++;
    push_keep(b, 4);
    if (fill == 4 && {win[0], win[1], win[2], win[3]} == HDR_END_SEQ) begin
      mode = M_BODY;
      fill = 0;
      hdr_cnt = 0;
      return;
    end
    if (hdr_cnt >= MAX_HEADER_BYTES - 1) begin
      mode = M_DONE;
      fill = 0;
      emit(KIND_STATUS, 8'h00, ST_HDR_LIMIT);
    end
  endfunction

  function automatic void predict_beat(logic [7:0] b, logic sor, logic eor);
    int len, plen, clen;
    upload_beat_t r;
    step_q.delete();
    len = eff_len();
    plen = len + 2;
    clen = len + 4;
    if (sor) clear_parse();
    case (mode)
      M_PREAMBLE: begin
        push_keep(b, plen);
        if (window_is(2, plen)) begin
          mode = M_EXPECT_CR;
          fill = 0;
        end
      end
      M_EXPECT_CR: begin
        if (b == CHR_CR) begin
          mode = M_EXPECT_LF;
        end else begin
          mode = M_HEADERS;
          header_byte(b);
        end
      end
      M_EXPECT_LF: begin
        mode = M_HEADERS;
        // a lone CR counts as a header byte
        if (b != CHR_LF) begin
          header_byte(CHR_CR);
          if (mode == M_HEADERS) header_byte(b);
        end
      end
      M_HEADERS: header_byte(b);
      M_BODY: begin
        push_keep(b, WIN_DEPTH);
        if (window_is(4, clen)) begin
          mode = M_DONE;
          fill = 0;
          emit(KIND_STATUS, 8'h00, body_seen ? ST_CLOSED : ST_NO_BODY);
        end else if (fill >= clen) begin
          emit(KIND_BYTE, win[0], ST_CLOSED);
          body_seen = 1'b1;
          drop_oldest();
          fill--;
        end
      end
      default: ;
    endcase
    if (eor) begin
      if (mode == M_BODY) begin
        for (int k = 0; k < fill; k++) begin
          emit(KIND_BYTE, win[k], ST_CLOSED);
          body_seen = 1'b1;
        end
        emit(KIND_STATUS, 8'h00, body_seen ? ST_NO_DELIM : ST_NO_BODY);
      end else if (mode != M_DONE) begin
        emit(KIND_STATUS, 8'h00, ST_NO_BODY);
      end
      clear_parse();
    end
    for (int i = 0; i < step_q.size(); i++) begin
      r = step_q[i];
      r.last = (i == step_q.size() - 1);
      expected_q.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_BND_REGS; r++) bnd_reg[r] = '0;
      bnd_len = BND_LEN_W'(1);
      clear_parse();
      expected_q.delete();
      fail_count_o = 0;
      byte_beats_o = 0;
      status_beats_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i < CFG_IDX_LEN) bnd_reg[cfg_idx_i] = cfg_wdata_i;
        else if (cfg_idx_i == CFG_IDX_LEN) bnd_len = cfg_wdata_i[BND_LEN_W-1:0];
      end
      if (in_valid_i && !in_stall_i)
        predict_beat(data_byte_i, start_of_request_i, end_of_request_i);
      if (out_valid_i && !out_stall_i) begin
        got.kind = result_kind_e'(result_kind_i);
        got.data = body_byte_i;
        got.status = end_status_e'(end_status_i);
        got.last = last_result_i;
        if (got.kind == KIND_STATUS) status_beats_o++;
        else byte_beats_o++;
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result beat kind=%0d byte=%02h status=%0d last=%0d",
                     $realtime, got.kind, got.data, got.status, got.last);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"%0t: result mismatch: expected kind=%0d byte=%02h status=%0d",
                        " last=%0d, got kind=%0d byte=%02h status=%0d last=%0d"},
                       $realtime, want.kind, want.data, want.status, want.last,
                       got.kind, got.data, got.status, got.last);
          end
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

>>> test/tb_multipart_body_extractor.sv
// Testbench top for multipart_body_extractor: drives requests, boundary config
// and output back-pressure; mbe_checker does the prediction and comparison.
// Depends on mbe_pkg, mbe_checker and the block's RTL.
module tb_multipart_body_extractor;
  import mbe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    REQ_CLOSED,
    REQ_OPEN_END,
    REQ_TRUNCATED,
    REQ_LONE_CR,
    REQ_NOISE,
    REQ_RESTART
  } req_shape_e;

  localparam int NUM_PHASES   = 10;
  localparam int PHASE_BEATS  = 45;
  localparam int SETTLE_CYCLES = 80;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i = 8'h00;
  logic                  start_of_request_i = 1'b0;
  logic                  end_of_request_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  result_kind_o;
  logic [7:0]            body_byte_o;
  logic [1:0]            end_status_o;
  logic                  last_result_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  int fail_count, pending, byte_beats, status_beats;

  // stimulus-side copy of the boundary in use
  logic [7:0] bnd_bytes [MAX_BND];
  int         bnd_eff;
  logic [7:0] req_q [$];
  int         beats_sent;
  int         rand_base;
  bit         need_sor;
  bit         calm_tx;
  bit         calm_rx;
  int         rx_wait;

  multipart_body_extractor dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .data_byte_i, .start_of_request_i, .end_of_request_i,
    .out_valid_o, .out_stall_i,
    .result_kind_o, .body_byte_o, .end_status_o, .last_result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  mbe_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o),
    .data_byte_i, .start_of_request_i, .end_of_request_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .result_kind_i(result_kind_o), .body_byte_i(body_byte_o),
    .end_status_i(end_status_o), .last_result_i(last_result_o),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending),
    .byte_beats_o(byte_beats), .status_beats_o(status_beats)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receive side: random stall after each result beat, with calm stretches
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if ($urandom_range(0, 39) == 0) calm_rx = !calm_rx;
      rx_wait = calm_rx ? 0 : $urandom_range(0, 12);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall_i <= (rx_wait != 0);
  end

  task automatic send_beat(input logic [7:0] b, input logic sor, input logic eor);
    int gap;
    gap = calm_tx ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    start_of_request_i <= sor;
    end_of_request_i <= eor;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
  endtask

  // wait until every predicted result beat has been taken
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
  endtask

  // pattern: 0 all zero, 1 all ones, else random
  task automatic apply_config(input int len_val, input int pattern);
    logic [CFG_DATA_W-1:0] d;
    logic [CFG_DATA_W-1:0] regs [NUM_BND_REGS];
    for (int r = 0; r < NUM_BND_REGS; r++) begin
      if (pattern == 0) d = '0;
      else if (pattern == 1) d = '1;
      else d = {$urandom, $urandom};
      regs[r] = d;
      cfg_write(CFG_IDX_W'(r), d);
    end
    // upper bits beyond the length field are junk on purpose
    d = {$urandom, $urandom};
    d[BND_LEN_W-1:0] = BND_LEN_W'(len_val);
    cfg_write(CFG_IDX_LEN, d);
    cfg_we_i <= 1'b0;
    bnd_eff = len_val < 1 ? 1 : (len_val > MAX_BND ? MAX_BND : len_val);
    for (int i = 0; i < MAX_BND; i++) bnd_bytes[i] = regs[i >> 3][8 * (i & 7) +: 8];
  endtask

  function automatic logic [7:0] mixed_byte();
    case ($urandom_range(0, 9))
      0: return CHR_CR;
      1: return CHR_LF;
      2: return CHR_DASH;
      3: return bnd_bytes[$urandom_range(0, bnd_eff - 1)];
      default: return 8'($urandom);
    endcase
  endfunction

  // first n bytes of CR LF "--" boundary
  function automatic void push_delim_prefix(int n);
    for (int k = 0; k < n; k++) begin
      if (k == 0) req_q.push_back(CHR_CR);
      else if (k == 1) req_q.push_back(CHR_LF);
      else if (k < 4) req_q.push_back(CHR_DASH);
      else req_q.push_back(bnd_bytes[k - 4]);
    end
  endfunction

  function automatic void push_opening();
    req_q.push_back(CHR_DASH);
    req_q.push_back(CHR_DASH);
    for (int i = 0; i < bnd_eff; i++) req_q.push_back(bnd_bytes[i]);
  endfunction

  function automatic void build_request(req_shape_e shape);
    int n, cut;
    req_q.delete();
    if (shape == REQ_NOISE) begin
      n = $urandom_range(1, 15);
      repeat (n) req_q.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(0, 4)) req_q.push_back(mixed_byte());
    push_opening();
    if (shape == REQ_LONE_CR) begin
      req_q.push_back(CHR_CR);
      req_q.push_back(8'h78);
    end else if ($urandom_range(0, 3) != 0) begin
      req_q.push_back(CHR_CR);
      req_q.push_back(CHR_LF);
    end
    repeat ($urandom_range(0, 10)) req_q.push_back(mixed_byte());
    req_q.push_back(CHR_CR);
    req_q.push_back(CHR_LF);
    req_q.push_back(CHR_CR);
    req_q.push_back(CHR_LF);
    case ($urandom_range(0, 9))
      0, 1, 2: n = $urandom_range(0, 2);
      3:       n = $urandom_range(40, 70);
      default: n = $urandom_range(0, 20);
    endcase
    for (int i = 0; i < n; i++) begin
      // partial delimiters inside the body must pass through
      if ($urandom_range(0, 7) == 0) push_delim_prefix($urandom_range(1, bnd_eff + 3));
      else req_q.push_back(mixed_byte());
    end
    if (shape == REQ_CLOSED) begin
      push_delim_prefix(bnd_eff + 4);
      repeat ($urandom_range(0, 3)) req_q.push_back(mixed_byte());
    end
    if (shape == REQ_TRUNCATED || shape == REQ_RESTART) begin
      cut = $urandom_range(1, req_q.size());
      while (req_q.size() > cut) void'(req_q.pop_back());
    end
  endfunction

  task automatic post_request(input bit with_eor);
    bit sor_first;
    int last_i;
    sor_first = need_sor || $urandom_range(0, 7) != 0;
    calm_tx = $urandom_range(0, 3) == 0;
    last_i = req_q.size() - 1;
    for (int i = 0; i <= last_i; i++)
      send_beat(req_q[i], i == 0 && sor_first, with_eor && i == last_i);
    need_sor = !with_eor;
  endtask

  task automatic random_phase(input int phase);
    int reqs;
    req_shape_e shape;
    int pick;
    reqs = 0;
    // phases share one beat budget, so a long request shortens the next phase
    while (beats_sent - rand_base < (phase + 1) * PHASE_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) shape = REQ_CLOSED;
      else if (pick < 65) shape = REQ_OPEN_END;
      else if (pick < 75) shape = REQ_TRUNCATED;
      else if (pick < 83) shape = REQ_LONE_CR;
      else if (pick < 90) shape = REQ_NOISE;
      else shape = REQ_RESTART;
      if ((phase == 1 && reqs == 1) || $urandom_range(0, 24) == 0) drain();
      build_request(shape);
      post_request(shape != REQ_RESTART);
      reqs++;
    end
  endtask

  initial begin
    int len_plan [NUM_PHASES];
    int len_val, pattern;
    len_plan = '{1, 1, 56, 0, 63, 3, 2, 8, 57, -1};
    beats_sent = 0;
    rand_base = 0;
    need_sor = 1'b1;
    calm_tx = 1'b0;
    calm_rx = 1'b0;
    rx_wait = 0;
    // reset values: one boundary byte of zero
    bnd_eff = 1;
    for (int i = 0; i < MAX_BND; i++) bnd_bytes[i] = 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single beat that both starts and ends a request
    req_q = '{8'h00};
    post_request(1'b1);
    // delimiter right after the headers: no body data
    req_q.delete();
    push_opening();
    req_q.push_back(CHR_CR);
    req_q.push_back(CHR_LF);
    push_delim_prefix(2);
    push_delim_prefix(2);
    push_delim_prefix(4 + bnd_eff);
    post_request(1'b1);
    // no CRLF after the boundary, request ends inside the body
    req_q.delete();
    push_opening();
    req_q.push_back(8'h78);
    push_delim_prefix(2);
    push_delim_prefix(2);
    req_q.push_back(8'hFF);
    req_q.push_back(8'h00);
    post_request(1'b1);

    rand_base = beats_sent;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        settle();
        len_val = len_plan[p] < 0 ? $urandom_range(1, 63) : len_plan[p];
        pattern = p == 2 ? 1 : (p == 4 || p == 1 ? 0 : 2);
        apply_config(len_val, pattern);
      end
      random_phase(p);
    end

    settle();
    $display("%0d input beats over %0d boundary settings gave %0d body bytes and %0d statuses",
             beats_sent, NUM_PHASES, byte_beats, status_beats);
    $display("lengths 1 to 56, clamped lengths, empty bodies, restarts and flushes exercised");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_multipart_body_extractor passed");
    end else begin
      $display("tb_multipart_body_extractor failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("tb_multipart_body_extractor failed");
    $finish;
  end

endmodule
